[src/msm_pkg.sv]
// ----------------------------------------------------------------------------
// msm_pkg
// signature rom, lengths and shared widths for the magic signature matcher
// ----------------------------------------------------------------------------
package msm_pkg;

   localparam int SIG_COUNT = 10;
   localparam int SIG_MAX   = 20;
   localparam int LEN_W     = 5;
   localparam int ROM_IDX_W = 5;
   localparam int SIG_IDX_W = 4;

   typedef logic [7:0]           byte_type;
   typedef logic [SIG_COUNT-1:0] sig_vec_type;
   typedef logic [SIG_IDX_W-1:0] sig_idx_type;

   localparam logic [LEN_W-1:0] SIG_LEN [SIG_COUNT] = '{
      5'd8, 5'd4, 5'd8, 5'd8, 5'd6, 5'd4, 5'd20, 5'd4, 5'd8, 5'd4
   };

   localparam byte_type SIG_ROM [SIG_COUNT][SIG_MAX] = '{
      '{8'h3C, 8'h72, 8'h6F, 8'h62, 8'h6C, 8'h6F, 8'h78, 8'h21, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h1B, 8'h4C, 8'h75, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h66, 8'h74, 8'h79, 8'h70, 8'h69, 8'h73, 8'h6F, 8'h6D, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h66, 8'h74, 8'h79, 8'h70, 8'h4D, 8'h53, 8'h4E, 8'h56, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hCF, 8'hFA, 8'hED, 8'hFE, 8'h0C, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h11, 8'h00, 8'h00, 8'h00},
      '{8'h25, 8'h50, 8'h44, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

endpackage

[src/msm_match.sv]
// ----------------------------------------------------------------------------
// msm_match
// per-signature byte compare, alive update and full-match detection
// ----------------------------------------------------------------------------
module msm_match
   import msm_pkg::*;
#(
   parameter int POS_W = 5
) (
   input  byte_type        data_byte,
   input  logic [POS_W-1:0] position,
   input  sig_vec_type     alive,
   output sig_vec_type     alive_next,
   output sig_vec_type     complete
);

   logic [POS_W:0] count;

   assign count = {1'b0, position} + {{POS_W{1'b0}}, 1'b1};

   always_comb begin
      for (int i = 0; i < SIG_COUNT; i++) begin
         logic [POS_W:0] len_ext;
         logic           in_sig;
         len_ext = {{(POS_W+1-LEN_W){1'b0}}, SIG_LEN[i]};
         in_sig  = ({1'b0, position} < len_ext);
         if (in_sig && (SIG_ROM[i][position[ROM_IDX_W-1:0]] != data_byte)) begin
            alive_next[i] = 1'b0;
         end else begin
            alive_next[i] = alive[i];
         end
         complete[i] = alive_next[i] && (len_ext <= count);
      end
   end

endmodule

[src/magic_signature_matcher.sv]
// ----------------------------------------------------------------------------
// magic_signature_matcher
// classifies a file by its leading bytes against a rom of magic signatures
// ----------------------------------------------------------------------------
// a result is registered from its accepted word and shows on rsp_ in the next cycle
// throughput: one word per cycle while rsp_ is not stalled; compare and update sit in one register stage
// a result is given at word PREFIX_BYTES or at end_of_file, whichever is first
// reset: synchronous, clears position, sets all alive flags, drops rsp_valid
// ----------------------------------------------------------------------------
module magic_signature_matcher
   import msm_pkg::*;
#(
   parameter int PREFIX_BYTES = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [3:0]  rsp_signature_index
);

   localparam int POS_W = $clog2(PREFIX_BYTES);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(PREFIX_BYTES - 1);

   logic [POS_W-1:0] position_ff, position_in;
   sig_vec_type      alive_ff, alive_in;
   logic             reported_ff, reported_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             found_ff, found_in;
   sig_idx_type      index_ff, index_in;

   sig_vec_type      alive_next;
   sig_vec_type      complete;
   logic             accept;
   logic             report;

   msm_match #(
      .POS_W (POS_W)
   ) u_match (
      .data_byte  (req_data_byte),
      .position   (position_ff),
      .alive      (alive_ff),
      .alive_next (alive_next),
      .complete   (complete)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign report    = accept && !reported_ff
                      && (req_end_of_file || (position_ff == LAST_POS));

   always_comb begin
      position_in  = position_ff;
      alive_in     = alive_ff;
      reported_in  = reported_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in     = found_ff;
      index_in     = index_ff;

      // lowest index wins
      if (report) begin
         found_in = |complete;
         index_in = '0;
         for (int i = SIG_COUNT - 1; i >= 0; i--) begin
            if (complete[i]) begin
               index_in = SIG_IDX_W'(i);
            end
         end
         rsp_valid_in = 1'b1;
      end

      if (accept) begin
         if (req_end_of_file) begin
            position_in = '0;
            alive_in    = '1;
            reported_in = 1'b0;
         end else if (!reported_ff) begin
            alive_in = alive_next;
            if (report) begin
               reported_in = 1'b1;
            end else begin
               position_in = position_ff + {{(POS_W-1){1'b0}}, 1'b1};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         alive_ff     <= '1;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         position_ff  <= position_in;
         alive_ff     <= alive_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      index_ff <= index_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = found_ff;
   assign rsp_signature_index = index_ff;

endmodule
